/* rtl/core/csb_pkg.sv */
// Shared types, codes and calendar helpers for the clock setting button FSM.
// No dependencies; compiled first.
`default_nettype none

package csb_pkg;

    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int HOLD_W   = 10;
    localparam int VIEW_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam logic [HOLD_W-1:0] HOLD_MAX = 10'd1023;

    localparam logic [HOLD_W-1:0] SKIP_DELAY_RST = 10'd1000;
    localparam logic [YEAR_W-1:0] YEAR_FLOOR_RST = 14'd2000;
    localparam logic [YEAR_W-1:0] YEAR_CEIL_RST  = 14'd2099;

    // y divisible by 25 <=> (y * 25^-1 mod 2^14) <= floor((2^14-1)/25)
    localparam logic [YEAR_W-1:0] INV25      = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_LIM  = 14'd655;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SKIP_DELAY = 2'd0,
        CFG_YEAR_FLOOR = 2'd1,
        CFG_YEAR_CEIL  = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        FLD_HOUR   = 3'd0,
        FLD_MINUTE = 3'd1,
        FLD_DAY    = 3'd2,
        FLD_MONTH  = 3'd3,
        FLD_YEAR   = 3'd4
    } field_t;

    localparam logic [VIEW_W-1:0] VIEW_ALL   = 3'd0;
    localparam logic [VIEW_W-1:0] VIEW_BLANK = 3'd1;
    localparam logic [VIEW_W-1:0] VIEW_HOUR  = 3'd2;

    typedef struct packed {
        logic [HOLD_W-1:0] skip_delay_ticks;
        logic [YEAR_W-1:0] year_floor;
        logic [YEAR_W-1:0] year_ceil;
    } csb_cfg_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
    } csb_time_t;

    typedef struct packed {
        logic                up_pressed;
        logic                down_pressed;
        logic                set_pressed;
        logic                clock_pressed;
        logic                osc_fault;
        logic [HOUR_W-1:0]   cur_hour;
        logic [MINUTE_W-1:0] cur_minute;
        logic [SECOND_W-1:0] cur_second;
        logic [DAY_W-1:0]    cur_day;
        logic [MONTH_W-1:0]  cur_month;
        logic [YEAR_W-1:0]   cur_year;
    } csb_in_t;

    typedef struct packed {
        logic                write_time;
        logic                clear_fault;
        logic [HOUR_W-1:0]   new_hour;
        logic [MINUTE_W-1:0] new_minute;
        logic [SECOND_W-1:0] new_second;
        logic [DAY_W-1:0]    new_day;
        logic [MONTH_W-1:0]  new_month;
        logic [YEAR_W-1:0]   new_year;
        logic [VIEW_W-1:0]   view;
    } csb_out_t;

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] p;
        logic              div25;
        p     = YEAR_W'(y * INV25);
        div25 = (p <= DIV25_LIM);
        return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    // Days in month; out-of-range month counts as 31.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DAY_W-1:0] d;
        case (m)
            4'd2:    d = leap ? 5'd29 : 5'd28;
            4'd4:    d = 5'd30;
            4'd6:    d = 5'd30;
            4'd9:    d = 5'd30;
            4'd11:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/csb_if.sv */
// Valid/ready channel interfaces for input items and result items.
// Depends on csb_pkg.
`default_nettype none

interface csb_in_if;
    logic              valid;
    logic              ready;
    csb_pkg::csb_in_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface csb_out_if;
    logic              valid;
    logic              ready;
    csb_pkg::csb_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/csb_cfg_regs.sv */
// Configuration registers: skip delay and year limits.
// Depends on csb_pkg.
`default_nettype none

module csb_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [csb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [csb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output csb_pkg::csb_cfg_t                     cfg
);
    import csb_pkg::*;

    csb_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.skip_delay_ticks <= SKIP_DELAY_RST;
            cfg_reg.year_floor       <= YEAR_FLOOR_RST;
            cfg_reg.year_ceil        <= YEAR_CEIL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SKIP_DELAY: cfg_reg.skip_delay_ticks <= cfg_wdata[HOLD_W-1:0];
                CFG_YEAR_FLOOR: cfg_reg.year_floor       <= cfg_wdata[YEAR_W-1:0];
                CFG_YEAR_CEIL:  cfg_reg.year_ceil        <= cfg_wdata[YEAR_W-1:0];
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/core/csb_adjust.sv */
// One up/down step of a selected time field, with wrap and calendar limits.
// Depends on csb_pkg.
`default_nettype none

module csb_adjust (
    input  wire csb_pkg::field_t       fld,
    input  wire logic                  up,
    input  wire logic                  down,
    input  wire csb_pkg::csb_time_t    t_in,
    input  wire csb_pkg::csb_cfg_t     cfg,
    output csb_pkg::csb_time_t         t_out,
    output logic                       wr
);
    import csb_pkg::*;

    logic [HOUR_W:0]   hour_inc;
    logic [MINUTE_W:0] minute_inc;
    logic [DAY_W:0]    day_inc;
    logic [MONTH_W:0]  month_inc;
    logic [YEAR_W:0]   year_inc;
    logic [DAY_W-1:0]  day_lim;

    assign hour_inc   = {1'b0, t_in.hour} + 6'd1;
    assign minute_inc = {1'b0, t_in.minute} + 7'd1;
    assign day_inc    = {1'b0, t_in.day} + 6'd1;
    assign month_inc  = {1'b0, t_in.month} + 5'd1;
    assign year_inc   = {1'b0, t_in.year} + 15'd1;
    assign day_lim    = month_days(t_in.month, is_leap(t_in.year));

    always_comb
    begin
        t_out = t_in;
        wr    = 1'b0;
        if (!(up && down))
        begin
            wr = 1'b1;
            case (fld)
                FLD_HOUR:
                begin
                    if (up)
                        t_out.hour = (hour_inc >= 6'd24) ? '0 : hour_inc[HOUR_W-1:0];
                    else if (down)
                        t_out.hour = (t_in.hour == '0) ? 5'd23 : t_in.hour - 5'd1;
                    if (up || down)
                        t_out.second = '0;
                end
                FLD_MINUTE:
                begin
                    if (up)
                    begin
                        t_out.minute = (minute_inc >= 7'd60) ? '0
                                                             : minute_inc[MINUTE_W-1:0];
                        t_out.second = '0;
                    end
                    else if (down)
                        t_out.minute = (t_in.minute == '0) ? 6'd59 : t_in.minute - 6'd1;
                end
                FLD_DAY:
                begin
                    if (up)
                        t_out.day = (day_inc > {1'b0, day_lim}) ? 5'd1 : day_inc[DAY_W-1:0];
                    else if (down)
                        t_out.day = (t_in.day <= 5'd1) ? day_lim : t_in.day - 5'd1;
                end
                FLD_MONTH:
                begin
                    if (up)
                        t_out.month = (month_inc > 5'd12) ? 4'd1 : month_inc[MONTH_W-1:0];
                    else if (down)
                        t_out.month = (t_in.month <= 4'd1) ? 4'd12 : t_in.month - 4'd1;
                end
                default:
                begin
                    if (up)
                        t_out.year = (year_inc > {1'b0, cfg.year_ceil}) ? cfg.year_floor
                                                                        : year_inc[YEAR_W-1:0];
                    else if (down)
                        t_out.year = (t_in.year <= cfg.year_floor) ? cfg.year_ceil
                                                                   : t_in.year - 14'd1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/csb_fsm.sv */
// Set-time state machine: hold timer, state register and result register.
// Depends on csb_pkg and csb_adjust.
`default_nettype none

module csb_fsm (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  wire csb_pkg::csb_in_t    item,
    input  wire csb_pkg::csb_cfg_t   cfg,
    output csb_pkg::csb_out_t        result
);
    import csb_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE       = 5'd0,
        ST_DEB_IDLE   = 5'd1,
        ST_BLINKING   = 5'd2,
        ST_SET_HOUR   = 5'd3,
        ST_FAST_HOUR  = 5'd4,
        ST_DEB_HOUR   = 5'd5,
        ST_SET_MIN    = 5'd6,
        ST_FAST_MIN   = 5'd7,
        ST_DEB_MIN    = 5'd8,
        ST_SET_DAY    = 5'd9,
        ST_FAST_DAY   = 5'd10,
        ST_DEB_DAY    = 5'd11,
        ST_SET_MONTH  = 5'd12,
        ST_FAST_MONTH = 5'd13,
        ST_DEB_MONTH  = 5'd14,
        ST_SET_YEAR   = 5'd15,
        ST_FAST_YEAR  = 5'd16,
        ST_DEB_YEAR   = 5'd17
    } state_t;

    typedef enum logic [1:0] {
        K_NONE,
        K_SET,
        K_FAST,
        K_DEB
    } kind_t;

    state_t            state_reg, state_next;
    logic              skip_reg, skip_next;
    logic [HOLD_W-1:0] hold_reg, hold_next, hold_pre;
    csb_out_t          result_reg, result_next;

    kind_t      kind;
    field_t     fld;
    csb_time_t  t_cur, t_adj;
    logic       adj_wr;
    logic       any_btn, arrows, phase;
    logic [VIEW_W-1:0] blink_view;

    function automatic state_t st_set(input field_t f);
        state_t s;
        case (f)
            FLD_HOUR:   s = ST_SET_HOUR;
            FLD_MINUTE: s = ST_SET_MIN;
            FLD_DAY:    s = ST_SET_DAY;
            FLD_MONTH:  s = ST_SET_MONTH;
            default:    s = ST_SET_YEAR;
        endcase
        return s;
    endfunction

    function automatic state_t st_fast(input field_t f);
        state_t s;
        case (f)
            FLD_HOUR:   s = ST_FAST_HOUR;
            FLD_MINUTE: s = ST_FAST_MIN;
            FLD_DAY:    s = ST_FAST_DAY;
            FLD_MONTH:  s = ST_FAST_MONTH;
            default:    s = ST_FAST_YEAR;
        endcase
        return s;
    endfunction

    function automatic state_t st_deb(input field_t f);
        state_t s;
        case (f)
            FLD_HOUR:   s = ST_DEB_HOUR;
            FLD_MINUTE: s = ST_DEB_MIN;
            FLD_DAY:    s = ST_DEB_DAY;
            FLD_MONTH:  s = ST_DEB_MONTH;
            default:    s = ST_DEB_YEAR;
        endcase
        return s;
    endfunction

    function automatic field_t next_field(input field_t f);
        field_t n;
        case (f)
            FLD_HOUR:   n = FLD_MINUTE;
            FLD_MINUTE: n = FLD_DAY;
            FLD_DAY:    n = FLD_MONTH;
            default:    n = FLD_YEAR;
        endcase
        return n;
    endfunction

    assign t_cur.hour   = item.cur_hour;
    assign t_cur.minute = item.cur_minute;
    assign t_cur.second = item.cur_second;
    assign t_cur.day    = item.cur_day;
    assign t_cur.month  = item.cur_month;
    assign t_cur.year   = item.cur_year;

    assign any_btn = item.up_pressed || item.down_pressed || item.set_pressed
                     || item.clock_pressed;
    assign arrows  = item.up_pressed || item.down_pressed;
    assign phase   = item.cur_second[0];

    // Hold timer runs ahead of the transition test.
    assign hold_pre = !skip_reg ? '0 :
                      (hold_reg == HOLD_MAX) ? hold_reg : hold_reg + 10'd1;

    always_comb
    begin
        kind = K_NONE;
        fld  = FLD_HOUR;
        case (state_reg)
            ST_SET_HOUR:   begin kind = K_SET;  fld = FLD_HOUR;   end
            ST_FAST_HOUR:  begin kind = K_FAST; fld = FLD_HOUR;   end
            ST_DEB_HOUR:   begin kind = K_DEB;  fld = FLD_HOUR;   end
            ST_SET_MIN:    begin kind = K_SET;  fld = FLD_MINUTE; end
            ST_FAST_MIN:   begin kind = K_FAST; fld = FLD_MINUTE; end
            ST_DEB_MIN:    begin kind = K_DEB;  fld = FLD_MINUTE; end
            ST_SET_DAY:    begin kind = K_SET;  fld = FLD_DAY;    end
            ST_FAST_DAY:   begin kind = K_FAST; fld = FLD_DAY;    end
            ST_DEB_DAY:    begin kind = K_DEB;  fld = FLD_DAY;    end
            ST_SET_MONTH:  begin kind = K_SET;  fld = FLD_MONTH;  end
            ST_FAST_MONTH: begin kind = K_FAST; fld = FLD_MONTH;  end
            ST_DEB_MONTH:  begin kind = K_DEB;  fld = FLD_MONTH;  end
            ST_SET_YEAR:   begin kind = K_SET;  fld = FLD_YEAR;   end
            ST_FAST_YEAR:  begin kind = K_FAST; fld = FLD_YEAR;   end
            ST_DEB_YEAR:   begin kind = K_DEB;  fld = FLD_YEAR;   end
            default:       begin kind = K_NONE; fld = FLD_HOUR;   end
        endcase
    end

    assign blink_view = phase ? VIEW_ALL : VIEW_W'(VIEW_HOUR + VIEW_W'(fld));

    csb_adjust u_adjust (
        .fld   (fld),
        .up    (item.up_pressed),
        .down  (item.down_pressed),
        .t_in  (t_cur),
        .cfg   (cfg),
        .t_out (t_adj),
        .wr    (adj_wr)
    );

    always_comb
    begin
        csb_time_t t_new;
        logic      wr, clr;
        logic [VIEW_W-1:0] view;

        state_next = state_reg;
        skip_next  = skip_reg;
        hold_next  = hold_pre;
        t_new      = t_cur;
        wr         = 1'b0;
        clr        = 1'b0;
        view       = VIEW_ALL;

        case (kind)
            K_SET:
            begin
                if (!any_btn)
                begin
                    skip_next = 1'b0;
                    view      = blink_view;
                end
                else if (item.clock_pressed)
                begin
                    state_next = ST_DEB_IDLE;
                    wr         = 1'b1;
                end
                else if (item.set_pressed)
                begin
                    if (fld == FLD_YEAR)
                    begin
                        state_next = ST_DEB_IDLE;
                        wr         = 1'b1;
                    end
                    else
                    begin
                        state_next = st_deb(next_field(fld));
                        skip_next  = 1'b0;
                        view       = phase ? VIEW_ALL
                                           : VIEW_W'(VIEW_HOUR + VIEW_W'(next_field(fld)));
                    end
                end
                else
                begin
                    state_next = st_deb(fld);
                    skip_next  = 1'b1;
                    hold_next  = '0;
                    t_new      = t_adj;
                    wr         = adj_wr;
                end
            end
            K_FAST:
            begin
                if (arrows)
                begin
                    t_new = t_adj;
                    wr    = adj_wr;
                end
                else if (!any_btn)
                begin
                    state_next = st_set(fld);
                    skip_next  = 1'b0;
                    view       = blink_view;
                end
            end
            K_DEB:
            begin
                if (!any_btn)
                begin
                    state_next = st_set(fld);
                    skip_next  = 1'b0;
                    view       = blink_view;
                end
                else if (arrows && skip_reg && (hold_pre >= cfg.skip_delay_ticks))
                begin
                    state_next = st_fast(fld);
                    skip_next  = 1'b0;
                end
            end
            default:
            begin
                case (state_reg)
                    ST_DEB_IDLE:
                    begin
                        if (!any_btn)
                            state_next = ST_IDLE;
                    end
                    ST_BLINKING:
                    begin
                        if (item.clock_pressed)
                        begin
                            clr        = 1'b1;
                            state_next = ST_DEB_HOUR;
                        end
                        else if (item.osc_fault)
                            view = phase ? VIEW_ALL : VIEW_BLANK;
                        else
                            state_next = ST_IDLE;
                    end
                    default:
                    begin
                        if (item.osc_fault)
                        begin
                            view       = phase ? VIEW_ALL : VIEW_BLANK;
                            state_next = ST_BLINKING;
                        end
                        else if (item.clock_pressed)
                            state_next = ST_DEB_HOUR;
                        else
                            state_next = ST_IDLE;
                    end
                endcase
            end
        endcase

        result_next.write_time  = wr;
        result_next.clear_fault = clr;
        result_next.new_hour    = t_new.hour;
        result_next.new_minute  = t_new.minute;
        result_next.new_second  = t_new.second;
        result_next.new_day     = t_new.day;
        result_next.new_month   = t_new.month;
        result_next.new_year    = t_new.year;
        result_next.view        = view;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            skip_reg   <= 1'b0;
            hold_reg   <= '0;
            result_reg <= '0;
        end
        else if (take)
        begin
            state_reg  <= state_next;
            skip_reg   <= skip_next;
            hold_reg   <= hold_next;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

/* rtl/core/clock_setting_button_fsm.sv */
// Clock setting button FSM: one item per cycle sustained while the output is
// not stalled. An accepted item goes through the input register, then one
// pass of next-state and field-step logic into the result register. The
// result register is refilled when it is empty or the downstream side takes
// its item, so a stalled output also stalls the input. Config writes are
// taken at any time and apply to items processed afterward. Depends on
// csb_pkg, csb_if, csb_cfg_regs, csb_fsm and csb_adjust.
`default_nettype none

module clock_setting_button_fsm (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [csb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [csb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    csb_in_if.sink                               in_ch,
    csb_out_if.source                            out_ch
);
    import csb_pkg::*;

    csb_cfg_t cfg;
    csb_in_t  s1_item_reg;
    logic     s1_valid_reg;
    logic     out_valid_reg;
    logic     take;

    assign take        = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
                s1_valid_reg <= in_ch.valid;
            if (take)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            s1_item_reg <= in_ch.data;
    end

    csb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    csb_fsm u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (s1_item_reg),
        .cfg    (cfg),
        .result (out_ch.data)
    );

    assign out_ch.valid = out_valid_reg;

endmodule

`default_nettype wire
